>>> rtl/integer_stack_machine_core_defines.svh
// Assertion macros used by the integer stack machine core.
`ifndef INTEGER_STACK_MACHINE_CORE_DEFINES_SVH
`define INTEGER_STACK_MACHINE_CORE_DEFINES_SVH

// Clocked assertion that is switched off while reset is held.
`define ISM_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ISM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/ism_pkg.sv
// Types and constants of the integer stack machine.
`default_nettype none

package ism_pkg;

    localparam int WORD_W  = 32;
    localparam int MODE_W  = 4;
    localparam int DEPTH_W = 9;
    localparam int STAT_W  = 2;

    typedef enum logic [MODE_W-1:0] {
        OP_CONST = 4'd0,
        OP_ADD   = 4'd1,
        OP_SUB   = 4'd2,
        OP_MUL   = 4'd3,
        OP_DIV   = 4'd4,
        OP_MAX   = 4'd5,
        OP_MIN   = 4'd6,
        OP_NEG   = 4'd7,
        OP_DUP   = 4'd8,
        OP_SWAP  = 4'd9,
        OP_END   = 4'd10
    } t_opcode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIVZ  = 2'd3
    } t_status;

endpackage

`default_nettype wire

>>> rtl/ism_if.sv
// Request and result channel interfaces of the integer stack machine.
`default_nettype none

interface ism_in_if;
    logic                                valid;
    logic                                ready;
    logic [ism_pkg::MODE_W-1:0]          mode;
    logic signed [ism_pkg::WORD_W-1:0]   operand_value;

    modport source (output valid, output mode, output operand_value, input ready);
    modport sink   (input valid, input mode, input operand_value, output ready);
endinterface

interface ism_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [ism_pkg::WORD_W-1:0]   top_value;
    logic [ism_pkg::DEPTH_W-1:0]         stack_depth;
    logic [ism_pkg::STAT_W-1:0]          status;
    logic                                finished;

    modport source (output valid, output top_value, output stack_depth, output status,
                    output finished, input ready);
    modport sink   (input valid, input top_value, input stack_depth, input status,
                    input finished, output ready);
endinterface

`default_nettype wire

>>> rtl/integer_stack_machine_core.sv
// Integer stack machine: executes one stack instruction per request and returns one result.
//
// The top of the stack is held in a register and the entries below it in a single
// synchronous memory of STACK_DEPTH words; each instruction needs at most one read of
// that memory (the entry just below the top), issued as the request is accepted, and at
// most one write. Every instruction other than a DIV that reaches the divider is accepted in
// S_IDLE and completed in S_EXEC with the read data. A DIV with two operands and a non-zero
// divisor goes on to S_DIVW and waits there for the 32-step bit-serial divider and its
// completion flag. A new request is taken only while the core is idle and the
// output register is empty or being emptied in the same cycle, so a result that waits
// holds off the next request. The memory needs no clearing after reset, since only
// entries below the stack pointer are ever used.
`default_nettype none
`include "integer_stack_machine_core_defines.svh"

module integer_stack_machine_core #(
    parameter int STACK_DEPTH = 256
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ism_in_if.sink     i_cmd,
    ism_out_if.source  o_res
);

    localparam int W       = ism_pkg::WORD_W;
    localparam int DEPTH_W = ism_pkg::DEPTH_W;
    localparam int SPW     = $clog2(STACK_DEPTH + 1);
    localparam int AW      = $clog2(STACK_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DIVW = 3'b100
    } t_state;

    t_state                        r_state, n_state;
    logic [SPW-1:0]                r_sp, n_sp;
    logic [W-1:0]                  r_top, n_top;
    logic [ism_pkg::MODE_W-1:0]    r_mode;
    logic [W-1:0]                  r_operand;
    logic [W-1:0]                  r_rd_data;
    logic [W-1:0]                  r_mem [STACK_DEPTH];

    logic                          r_out_valid;
    logic [W-1:0]                  r_out_top;
    logic [DEPTH_W-1:0]            r_out_depth;
    ism_pkg::t_status              r_out_status;
    logic                          r_out_finished;

    logic                          w_accept;
    logic                          w_take;
    logic                          w_load;
    logic [W-1:0]                  w_report;
    logic [SPW-1:0]                w_report_sp;
    ism_pkg::t_status              w_status;
    logic                          w_finished;
    logic                          w_wr_en;
    logic [AW-1:0]                 w_wr_addr;
    logic [W-1:0]                  w_wr_data;
    logic [AW-1:0]                 w_rd_addr;
    logic                          w_div_start;
    logic                          w_div_done;
    logic [W-1:0]                  w_quotient;
    logic                          w_empty;
    logic                          w_full;
    logic                          w_lt2;
    logic [W-1:0]                  w_a;
    logic [W-1:0]                  w_b;
    logic [2*W-1:0]                w_prod;

    assign w_accept = i_cmd.valid && i_cmd.ready;
    assign w_take   = o_res.valid && o_res.ready;

    // The output register is free, or is emptied in this cycle, before a new request enters.
    assign i_cmd.ready = (r_state == S_IDLE) && (!r_out_valid || o_res.ready);

    assign w_rd_addr = AW'(r_sp - SPW'(2));
    assign w_empty   = (r_sp == '0);
    assign w_full    = (r_sp == SPW'(STACK_DEPTH));
    assign w_lt2     = (r_sp < SPW'(2));
    assign w_a       = r_top;
    assign w_b       = r_rd_data;
    assign w_prod    = w_a * w_b;

    ism_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_a),
        .i_divisor  (w_b),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    always_comb begin
        n_state     = r_state;
        n_sp        = r_sp;
        n_top       = r_top;
        w_status    = ism_pkg::ST_OK;
        w_finished  = 1'b0;
        w_wr_en     = 1'b0;
        w_wr_addr   = AW'(r_sp - SPW'(1));
        w_wr_data   = r_top;
        w_div_start = 1'b0;
        w_load      = 1'b0;
        w_report_sp = r_sp;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                w_load  = 1'b1;
                n_state = S_IDLE;
                case (r_mode)
                    ism_pkg::OP_CONST: begin
                        if (w_full) begin
                            w_status = ism_pkg::ST_OVER;
                        end else begin
                            w_wr_en = !w_empty;
                            n_top   = r_operand;
                            n_sp    = r_sp + SPW'(1);
                        end
                    end
                    ism_pkg::OP_ADD, ism_pkg::OP_SUB, ism_pkg::OP_MUL,
                    ism_pkg::OP_MAX, ism_pkg::OP_MIN: begin
                        if (w_lt2) begin
                            w_status = ism_pkg::ST_UNDER;
                        end else begin
                            n_sp = r_sp - SPW'(1);
                            case (r_mode)
                                ism_pkg::OP_ADD: n_top = w_a + w_b;
                                ism_pkg::OP_SUB: n_top = w_a - w_b;
                                ism_pkg::OP_MUL: n_top = w_prod[W-1:0];
                                ism_pkg::OP_MAX:
                                    n_top = ($signed(w_a) > $signed(w_b)) ? w_a : w_b;
                                default:
                                    n_top = ($signed(w_a) < $signed(w_b)) ? w_a : w_b;
                            endcase
                        end
                    end
                    ism_pkg::OP_DIV: begin
                        if (w_lt2) begin
                            w_status = ism_pkg::ST_UNDER;
                        end else if (w_b == '0) begin
                            w_status = ism_pkg::ST_DIVZ;
                        end else begin
                            w_div_start = 1'b1;
                            w_load      = 1'b0;
                            n_state     = S_DIVW;
                        end
                    end
                    ism_pkg::OP_NEG: begin
                        if (w_empty) begin
                            w_status = ism_pkg::ST_UNDER;
                        end else begin
                            n_top = '0 - r_top;
                        end
                    end
                    ism_pkg::OP_DUP: begin
                        if (w_empty) begin
                            w_status = ism_pkg::ST_UNDER;
                        end else if (w_full) begin
                            w_status = ism_pkg::ST_OVER;
                        end else begin
                            w_wr_en = 1'b1;
                            n_sp    = r_sp + SPW'(1);
                        end
                    end
                    ism_pkg::OP_SWAP: begin
                        if (w_lt2) begin
                            w_status = ism_pkg::ST_UNDER;
                        end else begin
                            w_wr_en   = 1'b1;
                            w_wr_addr = w_rd_addr;
                            n_top     = w_b;
                        end
                    end
                    ism_pkg::OP_END: begin
                        w_finished  = 1'b1;
                        n_sp        = '0;
                        if (w_empty) begin
                            w_status = ism_pkg::ST_UNDER;
                        end
                    end
                    default: begin
                        // Unused opcodes leave the stack as it is.
                    end
                endcase
                w_report_sp = w_finished ? r_sp : n_sp;
            end
            S_DIVW: begin
                if (w_div_done) begin
                    w_load      = 1'b1;
                    n_top       = w_quotient;
                    n_sp        = r_sp - SPW'(1);
                    w_report_sp = n_sp;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // END reports the top as it was before the stack is emptied.
    assign w_report = (w_report_sp == '0) ? '0 : (w_finished ? r_top : n_top);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sp    <= n_sp;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (w_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        if (w_accept) begin
            r_mode    <= i_cmd.mode;
            r_operand <= i_cmd.operand_value;
        end
        if (w_load) begin
            r_out_top      <= w_report;
            r_out_depth    <= w_finished ? '0 : DEPTH_W'(n_sp);
            r_out_status   <= w_status;
            r_out_finished <= w_finished;
        end
    end

    // Stack memory: entries below the top, one read and one write port.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_accept) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.top_value   = r_out_top;
    assign o_res.stack_depth = r_out_depth;
    assign o_res.status      = r_out_status;
    assign o_res.finished    = r_out_finished;

    `ISM_ASSERT_ALWAYS(a_sp_bound, i_clk, (!i_rst_n || (r_sp <= SPW'(STACK_DEPTH))), "stack pointer beyond depth")
    `ISM_ASSERT_CLK(a_accept_exec, i_clk, i_rst_n, (w_accept |=> (r_state == S_EXEC)), "request not executed")
    `ISM_ASSERT_CLK(a_div_done, i_clk, i_rst_n, (w_div_done |-> (r_state == S_DIVW)), "stray divider result")
    `ISM_ASSERT_CLK(a_out_source, i_clk, i_rst_n, ($rose(r_out_valid) |-> $past((r_state == S_EXEC) || (r_state == S_DIVW))), "result without instruction")

endmodule

`default_nettype wire

>>> rtl/ism_div.sv
// Bit-serial signed divider, truncating toward zero, one quotient bit per cycle.
`default_nettype none

module ism_div (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic [ism_pkg::WORD_W-1:0]         i_dividend,
    input  wire logic [ism_pkg::WORD_W-1:0]         i_divisor,
    output logic                                    o_done,
    output logic [ism_pkg::WORD_W-1:0]              o_quotient
);

    localparam int W   = ism_pkg::WORD_W;
    localparam int CNT_W = $clog2(W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_den;
    logic             r_neg;

    logic [W:0]       w_rem_sh;
    logic [W:0]       w_diff;
    logic             w_ge;
    logic [W-1:0]     w_mag_a;
    logic [W-1:0]     w_mag_b;

    assign w_mag_a  = i_dividend[W-1] ? (~i_dividend + W'(1)) : i_dividend;
    assign w_mag_b  = i_divisor[W-1]  ? (~i_divisor + W'(1))  : i_divisor;
    assign w_rem_sh = {r_rem, r_quo[W-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_den};
    assign w_ge     = !w_diff[W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= w_mag_a;
            r_den <= w_mag_b;
            r_neg <= i_dividend[W-1] ^ i_divisor[W-1];
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[W-1:0] : w_rem_sh[W-1:0];
            r_quo <= {r_quo[W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (~r_quo + W'(1)) : r_quo;

endmodule

`default_nettype wire

>>> verif/integer_stack_machine_core_tb.sv
// Self-checking testbench for integer_stack_machine_core: random programs against a stack predictor.
module integer_stack_machine_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ism_pkg::*;

    localparam int CLK_PERIOD = 20;
    localparam int STACK_SIZE = 256;
    localparam int NUM_REQUESTS = 1750;
    localparam int DRAIN_CYCLES = 60;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [WORD_W-1:0] operand;
    } t_instr;

    typedef struct packed {
        logic signed [WORD_W-1:0] top_value;
        logic [DEPTH_W-1:0]       stack_depth;
        t_status                  status;
        logic                     finished;
    } t_machine_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ism_in_if  cmd_bus ();
    ism_out_if res_bus ();

    integer_stack_machine_core #(
        .STACK_DEPTH(STACK_SIZE)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_bus),
        .o_res  (res_bus)
    );

    // Predicted machine state.
    logic [WORD_W-1:0] stack_mem [STACK_SIZE];
    int                stack_ptr = 0;

    t_instr          instr_queue[$];
    t_machine_result expected_results[$];

    int   accepted_count = 0;
    int   result_count = 0;
    int   error_count = 0;
    int   total_requests = 0;
    int   gen_depth = 0;
    int   burst_left = 1;
    int   gap_left = 0;
    int   stall_idx = 0;
    logic [31:0] stall_pattern = '1;
    logic long_hold = 1'b0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic t_machine_result execute_instruction(logic [MODE_W-1:0] mode,
                                                            logic [WORD_W-1:0] operand);
        t_machine_result res;
        logic [WORD_W-1:0] a, b, r, ma, mb, q;
        t_status st;
        st = ST_OK;
        r = '0;
        res.finished = 1'b0;
        a = (stack_ptr >= 1) ? stack_mem[stack_ptr - 1] : '0;
        b = (stack_ptr >= 2) ? stack_mem[stack_ptr - 2] : '0;
        case (mode)
            OP_CONST: begin
                if (stack_ptr >= STACK_SIZE) begin
                    st = ST_OVER;
                end else begin
                    stack_mem[stack_ptr] = operand;
                    stack_ptr++;
                end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MAX, OP_MIN: begin
                if (stack_ptr < 2) begin
                    st = ST_UNDER;
                end else begin
                    case (mode)
                        OP_ADD: r = a + b;
                        OP_SUB: r = a - b;
                        OP_MUL: r = a * b;
                        OP_DIV: begin
                            if (b == '0) begin
                                st = ST_DIVZ;
                            end else begin
                                // Divide magnitudes, then fix the sign: truncates toward zero
                                // and lets the most negative value over minus one wrap.
                                ma = a[WORD_W-1] ? -a : a;
                                mb = b[WORD_W-1] ? -b : b;
                                q = ma / mb;
                                r = (a[WORD_W-1] ^ b[WORD_W-1]) ? -q : q;
                            end
                        end
                        OP_MAX: r = ($signed(a) > $signed(b)) ? a : b;
                        default: r = ($signed(a) < $signed(b)) ? a : b;
                    endcase
                    if (st == ST_OK) begin
                        stack_ptr--;
                        stack_mem[stack_ptr - 1] = r;
                    end
                end
            end
            OP_NEG: begin
                if (stack_ptr < 1) st = ST_UNDER;
                else stack_mem[stack_ptr - 1] = -a;
            end
            OP_DUP: begin
                if (stack_ptr < 1) begin
                    st = ST_UNDER;
                end else if (stack_ptr >= STACK_SIZE) begin
                    st = ST_OVER;
                end else begin
                    stack_mem[stack_ptr] = a;
                    stack_ptr++;
                end
            end
            OP_SWAP: begin
                if (stack_ptr < 2) begin
                    st = ST_UNDER;
                end else begin
                    stack_mem[stack_ptr - 1] = b;
                    stack_mem[stack_ptr - 2] = a;
                end
            end
            OP_END: begin
                res.finished = 1'b1;
                if (stack_ptr == 0) st = ST_UNDER;
                stack_ptr = 0;
            end
            default: ;
        endcase
        if (mode == OP_END) res.top_value = a;
        else res.top_value = (stack_ptr == 0) ? '0 : stack_mem[stack_ptr - 1];
        res.stack_depth = DEPTH_W'(stack_ptr);
        res.status = st;
        return res;
    endfunction

    function automatic logic [WORD_W-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return 32'd1;
            5, 6: return WORD_W'($urandom_range(0, 200) - 100);
            default: return $urandom;
        endcase
    endfunction

    // Queues a request and keeps a rough count of the stack depth for shaping programs;
    // a division by zero is not foreseen, which only makes the count run a little low.
    task automatic queue_instr(logic [MODE_W-1:0] mode, logic [WORD_W-1:0] operand);
        t_instr item;
        item.mode = mode;
        item.operand = operand;
        instr_queue.push_back(item);
        case (mode)
            OP_CONST: if (gen_depth < STACK_SIZE) gen_depth++;
            OP_DUP: if (gen_depth >= 1 && gen_depth < STACK_SIZE) gen_depth++;
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MAX, OP_MIN: if (gen_depth >= 2) gen_depth--;
            OP_END: gen_depth = 0;
            default: ;
        endcase
    endtask

    // Request driver: bursts of requests separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_bus.valid <= 1'b0;
        end else begin
            if (cmd_bus.valid && cmd_bus.ready) begin
                expected_results.push_back(execute_instruction(cmd_bus.mode,
                                                               cmd_bus.operand_value));
                accepted_count++;
            end
            if (!cmd_bus.valid || cmd_bus.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    cmd_bus.valid <= 1'b0;
                end else if (instr_queue.size() != 0) begin
                    cmd_bus.valid <= 1'b1;
                    cmd_bus.mode <= instr_queue[0].mode;
                    cmd_bus.operand_value <= instr_queue[0].operand;
                    void'(instr_queue.pop_front());
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        case ($urandom_range(0, 7))
                            0, 1, 7: gap_left = 0;
                            6: gap_left = $urandom_range(5, 40);
                            default: gap_left = $urandom_range(1, 4);
                        endcase
                    end else begin
                        burst_left--;
                    end
                end else begin
                    cmd_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each result against the oldest prediction and stalls on a random
    // 32-bit pattern that is reloaded each time all of its bits have been used.
    always @(posedge i_clk) begin
        t_machine_result exp_res;
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
        end else begin
            if (res_bus.valid && res_bus.ready) begin
                result_count++;
                if (expected_results.size() == 0) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("result %0d arrived with no request outstanding: top %0d",
                                 result_count, res_bus.top_value);
                end else begin
                    exp_res = expected_results.pop_front();
                    if (res_bus.top_value !== exp_res.top_value ||
                        res_bus.stack_depth !== exp_res.stack_depth ||
                        res_bus.status !== exp_res.status ||
                        res_bus.finished !== exp_res.finished) begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                            $display("result %0d mismatch: expected top %0d depth %0d ",
                                     result_count, exp_res.top_value, exp_res.stack_depth,
                                     "status %0d finished %0b, got top %0d depth %0d ",
                                     exp_res.status, exp_res.finished, res_bus.top_value,
                                     res_bus.stack_depth,
                                     "status %0d finished %0b",
                                     res_bus.status, res_bus.finished);
                    end
                end
            end
            if (stall_idx == 0) begin
                case ($urandom_range(0, 3))
                    0: stall_pattern = '1;
                    1: stall_pattern = $urandom;
                    default: stall_pattern = $urandom | $urandom;
                endcase
            end
            res_bus.ready <= !long_hold && stall_pattern[stall_idx];
            stall_idx = (stall_idx + 1) % 32;
        end
    end

    // Long hold-offs on the result side so that the core fills up and refuses requests.
    initial begin
        wait (accepted_count >= 300);
        @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (300) @(posedge i_clk);
        long_hold <= 1'b0;
        wait (accepted_count >= 1000);
        @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (300) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    initial begin
        #15ms;
        $display("integer_stack_machine_core_tb: errors");
        $finish;
    end

    initial begin
        int plen;
        int r;
        int fills_done;
        logic [MODE_W-1:0] op;
        i_rst_n = 1'b0;
        cmd_bus.valid = 1'b0;
        cmd_bus.mode = '0;
        cmd_bus.operand_value = '0;
        res_bus.ready = 1'b0;

        // Errors on an empty stack and unknown opcodes.
        queue_instr(OP_END, 32'd5);
        queue_instr(OP_ADD, '0);
        queue_instr(OP_NEG, '0);
        queue_instr(OP_DUP, '0);
        queue_instr(4'd11, '1);
        queue_instr(4'd15, '1);
        // Wrapping arithmetic at the extremes.
        queue_instr(OP_CONST, 32'h7FFF_FFFF);
        queue_instr(OP_SWAP, '0);
        queue_instr(OP_CONST, 32'd1);
        queue_instr(OP_ADD, '0);
        queue_instr(OP_NEG, '0);
        queue_instr(OP_DUP, '0);
        queue_instr(OP_MUL, '0);
        queue_instr(OP_END, '0);
        // Most negative value divided by minus one.
        queue_instr(OP_CONST, '1);
        queue_instr(OP_CONST, 32'h8000_0000);
        queue_instr(OP_DIV, '0);
        // Divide by zero, then the remaining operations and an underflowing MIN.
        queue_instr(OP_CONST, '0);
        queue_instr(OP_CONST, 32'd5);
        queue_instr(OP_DIV, '0);
        queue_instr(OP_SUB, '0);
        queue_instr(OP_MAX, '0);
        queue_instr(OP_MIN, '0);
        queue_instr(OP_END, '0);

        fills_done = 0;
        while (instr_queue.size() < NUM_REQUESTS) begin
            // Now and then fill the stack to the brim to reach overflow and full depth.
            if (fills_done < 2 && instr_queue.size() >= 500 + 600 * fills_done) begin
                queue_instr(OP_END, pick_operand());
                while (gen_depth < STACK_SIZE)
                    queue_instr((gen_depth > 0 && $urandom_range(0, 3) == 0) ? OP_DUP : OP_CONST,
                                pick_operand());
                repeat (3) queue_instr($urandom_range(0, 1) ? OP_DUP : OP_CONST, pick_operand());
                repeat (6) queue_instr(MODE_W'($urandom_range(OP_ADD, OP_SWAP)), pick_operand());
                queue_instr(OP_END, pick_operand());
                fills_done++;
            end
            plen = $urandom_range(1, 30);
            repeat (plen) begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    op = MODE_W'($urandom_range(0, 15));
                else if (gen_depth < 2 && r < 85)
                    op = (gen_depth == 1 && r < 30) ? OP_DUP : OP_CONST;
                else if (r < 45)
                    op = OP_CONST;
                else
                    op = MODE_W'($urandom_range(OP_ADD, OP_SWAP));
                queue_instr(op, pick_operand());
            end
            // A few programs run on without END into the next one.
            if ($urandom_range(0, 9) != 0) queue_instr(OP_END, pick_operand());
        end
        total_requests = instr_queue.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_count < total_requests || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        error_count += expected_results.size();
        if (error_count == 0) begin
            $display("integer_stack_machine_core_tb: clean");
        end else begin
            $display("integer_stack_machine_core_tb: errors");
        end
        $finish;
    end

endmodule
